// ===== sv/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// Used by ffha_block_table and first_fit_heap_allocator; no dependencies.
package ffha_pkg;

    localparam int DEF_MAX_BLOCKS  = 256;
    localparam int DEF_ALIGN_BYTES = 8;
    localparam int HEADER_BYTES    = 24;

    localparam logic [31:0] BASE_ADDR_RST  = 32'h0010_0000;
    localparam logic [31:0] LIMIT_ADDR_RST = 32'h0020_0000;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDR  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_ADDR = CFG_INDEX_W'(1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_ZERO      = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_FULL      = 3'd3,
        ST_UNKNOWN   = 3'd4,
        ST_NULL      = 3'd5
    } status_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        free;
    } block_entry_t;

endpackage

// ===== sv/ffha_block_table.sv =====
// Block table memory: one write port, one read port with registered data.
// Depends on ffha_pkg for the entry type.
module ffha_block_table import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int IDX_W      = $clog2(MAX_BLOCKS)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  block_entry_t       wr_data,
    input  logic [IDX_W-1:0]   rd_addr,
    output block_entry_t       rd_data
);

    block_entry_t mem [MAX_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/first_fit_heap_allocator.sv =====
// First-fit heap allocator with a bump pointer: sequencer, scan and result register.
// Depends on ffha_pkg and ffha_block_table.
//
// Input stream s_*: one request per transfer. s_tuser is the operation (0 allocate,
// 1 free); s_tdata carries request_size in [31:0] and release_address in [63:32].
// Output stream m_*: one result per request. m_tdata is payload_address, m_tuser
// is the status code. Configuration writes (cfg_index 0 heap base, 1 heap limit)
// are always accepted and must only be issued while the block is idle.
// One request is worked at a time; s_tready is high only in the idle state.
// Zero-size allocate and null free go straight to the result. A free scans the table
// for the matching entry; an allocate rounds the size, scans for a free entry that fits,
// and else checks the heap limit and the table count and appends at the bump pointer.
// The table is scanned one entry per cycle through its registered read port, and
// sizes are rounded with a mask, so ALIGN_BYTES must be a power of two.
// s_tready is high again from the same edge that loads the result. While m_tready is low the
// result waits in the output register; the next request can be accepted and worked
// meanwhile, but its result holds until the register frees.
// Reset empties the table, loads the bump pointer from the heap base and restores
// the default heap bounds; no clearing pass is needed.
module first_fit_heap_allocator import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
    parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,   // request_size, release_address
    input  logic                   s_tuser,   // operation
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // payload_address
    output logic [2:0]             m_tuser,   // status
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    localparam logic [32:0]    ALIGN_M1 = 33'(ALIGN_BYTES - 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);
    localparam logic [34:0]    HDR_35   = 35'(HEADER_BYTES);
    localparam logic [31:0]    HDR_32   = 32'(HEADER_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_SCAN,
        S_CHECK,
        S_APPEND,
        S_RESULT
    } state_t;

    state_t          state_reg;
    logic            op_reg;
    logic [31:0]     req_reg;
    logic [31:0]     key_reg;
    logic [32:0]     rounded_reg;
    logic [34:0]     end_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic [32:0]     bump_reg;
    logic [31:0]     base_addr_reg;
    logic [31:0]     limit_addr_reg;
    logic [31:0]     res_addr_reg;
    status_t         res_status_reg;
    logic            m_tvalid_reg;
    logic [31:0]     m_tdata_reg;
    logic [2:0]      m_tuser_reg;

    logic [CNT_W-1:0] idx_next;
    logic            hit;
    logic            room;
    logic            wr_en;
    logic [IDX_W-1:0] wr_addr;
    block_entry_t    wr_data;
    block_entry_t    rd_data;

    ffha_block_table #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_next[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb
    begin
        idx_next  = (state_reg == S_SCAN) ? idx_reg + CNT_W'(1) : '0;
        if (op_reg == OP_FREE)
        begin
            hit = (rd_data.start == key_reg);
        end
        else
        begin
            hit = rd_data.free && ({1'b0, rd_data.size} >= rounded_reg);
        end
        room = (end_reg <= {3'b0, limit_addr_reg}) && (count_reg != MAX_CNT);

        wr_en   = 1'b0;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = rd_data;
        case (state_reg)
            S_SCAN:
            begin
                if (idx_reg != count_reg && hit)
                begin
                    wr_en        = 1'b1;
                    wr_data.free = (op_reg == OP_FREE);
                end
            end
            S_APPEND:
            begin
                wr_en         = room;
                wr_addr       = count_reg[IDX_W-1:0];
                wr_data.start = bump_reg[31:0];
                wr_data.size  = rounded_reg[31:0];
                wr_data.free  = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_ALLOC;
            req_reg        <= '0;
            key_reg        <= '0;
            rounded_reg    <= '0;
            end_reg        <= '0;
            idx_reg        <= '0;
            count_reg      <= '0;
            bump_reg       <= {1'b0, BASE_ADDR_RST};
            base_addr_reg  <= BASE_ADDR_RST;
            limit_addr_reg <= LIMIT_ADDR_RST;
            res_addr_reg   <= '0;
            res_status_reg <= ST_DONE;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
        end
        else
        begin
            if (state_reg == S_RESULT && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                if (cfg_index == CFG_BASE_ADDR)
                begin
                    base_addr_reg <= cfg_data;
                    if (count_reg == '0)
                    begin
                        bump_reg <= {1'b0, cfg_data};
                    end
                end
                else if (cfg_index == CFG_LIMIT_ADDR)
                begin
                    limit_addr_reg <= cfg_data;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg       <= s_tuser;
                        req_reg      <= s_tdata[31:0];
                        key_reg      <= s_tdata[63:32] - HDR_32;
                        res_addr_reg <= '0;
                        if (s_tuser == OP_FREE)
                        begin
                            if (s_tdata[63:32] == '0)
                            begin
                                res_status_reg <= ST_NULL;
                                state_reg      <= S_RESULT;
                            end
                            else
                            begin
                                res_status_reg <= ST_DONE;
                                state_reg      <= S_SCAN;
                            end
                        end
                        else if (s_tdata[31:0] == '0)
                        begin
                            res_status_reg <= ST_ZERO;
                            state_reg      <= S_RESULT;
                        end
                        else
                        begin
                            res_status_reg <= ST_DONE;
                            state_reg      <= S_ROUND;
                        end
                    end
                end
                S_ROUND:
                begin
                    rounded_reg <= ({1'b0, req_reg} + ALIGN_M1) & ~ALIGN_M1;
                    state_reg   <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (idx_reg == count_reg)
                    begin
                        idx_reg <= '0;
                        if (op_reg == OP_FREE)
                        begin
                            res_status_reg <= ST_UNKNOWN;
                            state_reg      <= S_RESULT;
                        end
                        else
                        begin
                            state_reg <= S_CHECK;
                        end
                    end
                    else if (hit)
                    begin
                        idx_reg <= '0;
                        if (op_reg == OP_ALLOC)
                        begin
                            res_addr_reg <= rd_data.start + HDR_32;
                        end
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        idx_reg <= idx_next;
                    end
                end
                S_CHECK:
                begin
                    end_reg   <= {2'b0, bump_reg} + {2'b0, rounded_reg} + HDR_35;
                    state_reg <= S_APPEND;
                end
                S_APPEND:
                begin
                    if (end_reg > {3'b0, limit_addr_reg})
                    begin
                        res_status_reg <= ST_EXHAUSTED;
                    end
                    else if (count_reg == MAX_CNT)
                    begin
                        res_status_reg <= ST_FULL;
                    end
                    else
                    begin
                        count_reg    <= count_reg + CNT_W'(1);
                        bump_reg     <= end_reg[32:0];
                        res_addr_reg <= bump_reg[31:0] + HDR_32;
                    end
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= res_addr_reg;
                        m_tuser_reg  <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for first_fit_heap_allocator: directed and random allocate/free
// traffic, heap bound register writes, and a built-in first-fit predictor.
// Depends on ffha_pkg and the allocator RTL only.
module testbench;
    import ffha_pkg::*;

    localparam int TB_MAX_BLOCKS = DEF_MAX_BLOCKS;
    localparam longint unsigned ALIGN = DEF_ALIGN_BYTES;
    localparam longint unsigned HDR = HEADER_BYTES;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = CFG_INDEX_W'(2);
    localparam int RANDOM_ITEMS = 520;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLDOFF_CYCLES = 500;
    localparam longint WATCHDOG_CYCLES = 2_000_000;

    typedef struct {
        logic        op;
        logic [31:0] size;
        logic [31:0] addr;
    } heap_request_t;

    typedef struct {
        logic [31:0] payload;
        status_t     status;
    } heap_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [63:0]            s_tdata = '0;
    logic                   s_tuser = OP_ALLOC;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [31:0]            m_tdata;
    logic [2:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_BASE_ADDR;
    logic [31:0]            cfg_data = '0;

    first_fit_heap_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor state
    logic [31:0] blk_start [TB_MAX_BLOCKS];
    logic [31:0] blk_size [TB_MAX_BLOCKS];
    logic        blk_free [TB_MAX_BLOCKS];
    int unsigned blk_count;
    logic [32:0] bump;
    logic [31:0] cur_base;
    logic [31:0] cur_limit;
    logic [31:0] known_payloads [$];

    heap_request_t pending_requests [$];
    heap_result_t  expected_results [$];
    heap_request_t next_request;
    heap_result_t  want;

    bit idling = 1'b1;
    int send_gap = 0;
    int sink_gap = 0;
    int holdoff_requests = 0;
    int holdoff_served = 0;
    int holdoff_left = 0;
    int mismatches = 0;
    int requests_queued = 0;
    int cfg_writes = 0;
    int status_tally [6] = '{default: 0};

    function automatic int draw_gap();
        if (!idling || $urandom_range(0, 3) != 0)
            return 0;
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    function automatic void reset_allocator_state();
        cur_base  = BASE_ADDR_RST;
        cur_limit = LIMIT_ADDR_RST;
        blk_count = 0;
        bump      = {1'b0, BASE_ADDR_RST};
        for (int k = 0; k < TB_MAX_BLOCKS; k++)
            blk_free[k] = 1'b0;
        known_payloads.delete();
        expected_results.delete();
    endfunction

    function automatic void apply_register_write(logic [CFG_INDEX_W-1:0] index,
                                                 logic [31:0] value);
        if (index == CFG_BASE_ADDR) begin
            cur_base = value;
            if (blk_count == 0)
                bump = {1'b0, value};
        end else if (index == CFG_LIMIT_ADDR) begin
            cur_limit = value;
        end
    endfunction

    function automatic heap_result_t predict_allocation(heap_request_t rq);
        heap_result_t res;
        logic [63:0]  rounded;
        logic [63:0]  total;
        bit           placed;
        res.payload = '0;
        res.status  = ST_DONE;
        placed      = 1'b0;
        if (rq.op == OP_ALLOC) begin
            if (rq.size == 0) begin
                res.status = ST_ZERO;
            end else begin
                rounded = ((64'(rq.size) + ALIGN - 1) / ALIGN) * ALIGN;
                for (int k = 0; k < blk_count && !placed; k++) begin
                    if (blk_free[k] && 64'(blk_size[k]) >= rounded) begin
                        blk_free[k] = 1'b0;
                        res.payload = blk_start[k] + 32'(HDR);
                        placed = 1'b1;
                    end
                end
                if (!placed) begin
                    total = HDR + rounded;
                    if (64'(bump) + total > 64'(cur_limit)) begin
                        res.status = ST_EXHAUSTED;
                    end else if (blk_count >= TB_MAX_BLOCKS) begin
                        res.status = ST_FULL;
                    end else begin
                        blk_start[blk_count] = bump[31:0];
                        blk_size[blk_count]  = rounded[31:0];
                        blk_free[blk_count]  = 1'b0;
                        res.payload = bump[31:0] + 32'(HDR);
                        known_payloads.push_back(res.payload);
                        blk_count++;
                        bump = 33'(64'(bump) + total);
                    end
                end
            end
        end else if (rq.addr == 0) begin
            res.status = ST_NULL;
        end else begin
            res.status = ST_UNKNOWN;
            for (int k = 0; k < blk_count && !placed; k++) begin
                if (blk_start[k] + 32'(HDR) == rq.addr) begin
                    blk_free[k] = 1'b1;
                    res.status = ST_DONE;
                    placed = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                next_request = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_request.op;
                s_tdata  <= {next_request.addr, next_request.size};
                send_gap <= draw_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            m_tready <= 1'b0;
        end else if (holdoff_served != holdoff_requests) begin
            holdoff_served <= holdoff_requests;
            holdoff_left <= HOLDOFF_CYCLES;
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            sink_gap <= draw_gap();
        end
    end

    // Monitor and scoreboard
    always @(posedge clk) begin
        if (!rst_n) begin
            reset_allocator_state();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %h/%0d with nothing outstanding",
                                              m_tdata, m_tuser));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.payload)
                        report_mismatch($sformatf("payload_address %h, expected %h",
                                                  m_tdata, want.payload));
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  m_tuser, want.status.name()));
                end
            end
            if (cfg_valid && cfg_ready)
                apply_register_write(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                next_request.op   = s_tuser;
                next_request.size = s_tdata[31:0];
                next_request.addr = s_tdata[63:32];
                want = predict_allocation(next_request);
                status_tally[int'(want.status)]++;
                expected_results.push_back(want);
            end
        end
    end

    task automatic push_request(logic op, logic [31:0] size, logic [31:0] addr);
        heap_request_t rq;
        while (pending_requests.size() >= 4)
            @(negedge clk);
        rq.op   = op;
        rq.size = size;
        rq.addr = addr;
        pending_requests.push_back(rq);
        requests_queued++;
    endtask

    task automatic alloc_req(logic [31:0] size);
        push_request(OP_ALLOC, size, 32'($urandom));
    endtask

    task automatic free_req(logic [31:0] addr);
        push_request(OP_FREE, 32'($urandom), addr);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] index, logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        @(negedge clk);
    endtask

    task automatic push_random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            alloc_req(32'($urandom_range(1, 300)));
        else if (r < 55)
            alloc_req(32'($urandom_range(1, 1 << 20)));
        else if (r < 58)
            alloc_req({24'hFF_FFFF, 8'($urandom)});
        else if (r < 60)
            alloc_req('0);
        else if (r < 90 && known_payloads.size() > 0)
            free_req(known_payloads[$urandom_range(0, known_payloads.size() - 1)]);
        else if (r < 94)
            free_req('0);
        else
            free_req(32'($urandom));
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #(WATCHDOG_CYCLES * 10);
        $display("Watchdog expired with %0d results outstanding", expected_results.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        @(posedge rst_n);
        @(negedge clk);

        // reset bounds, empty table
        alloc_req('0);
        free_req('0);
        free_req(32'hFFFF_FFFF);
        alloc_req(32'hFFFF_FFFF);
        wait_idle();

        // bump pointer already at the top of the address space
        cfg_write(CFG_BASE_ADDR, 32'hFFFF_FFFF);
        cfg_write(CFG_LIMIT_ADDR, 32'hFFFF_FFFF);
        alloc_req(32'd1);
        wait_idle();

        cfg_write(CFG_BASE_ADDR, 32'h0000_1000);
        cfg_write(CFG_LIMIT_ADDR, LIMIT_ADDR_RST);
        alloc_req(32'd1);
        alloc_req(32'd8);
        alloc_req(32'd9);
        alloc_req(32'hFFFF_FFF8);
        wait_idle();

        // double free, first-fit reuse, address off by one
        free_req(known_payloads[0]);
        free_req(known_payloads[0]);
        free_req(known_payloads[2]);
        alloc_req(32'd12);
        alloc_req(32'd3);
        free_req(known_payloads[1] + 32'd1);
        wait_idle();

        // exact fit against the heap limit, then past it
        cfg_write(CFG_LIMIT_ADDR, bump[31:0] + 32'(HDR) + 32'd64);
        alloc_req(32'd64);
        alloc_req(32'd1);
        wait_idle();

        cfg_write(CFG_LIMIT_ADDR, '0);
        cfg_write(CFG_UNMAPPED, 32'($urandom));
        alloc_req(32'd8);
        free_req(known_payloads[1]);
        alloc_req(32'd8);
        wait_idle();

        // heap base written after the table is in use: register only
        cfg_write(CFG_BASE_ADDR, '0);
        cfg_write(CFG_LIMIT_ADDR, 32'hFFFF_FFFF);

        idling = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 100)
                idling = 1'b1;
            if (i == 220)
                holdoff_requests++;
            if (i == 330)
                wait_idle();
            push_random_request();
        end
        wait_idle();

        // grow the table to capacity
        while (blk_count < TB_MAX_BLOCKS) begin
            repeat (16) alloc_req(32'($urandom_range(1, 64)));
            wait_idle();
        end
        alloc_req(32'h1000_0000);
        alloc_req(32'h1000_0000);
        alloc_req({24'hFF_FFFF, 8'($urandom)});
        free_req(known_payloads[5]);
        alloc_req(32'd1);
        alloc_req(32'h1000_0000);
        free_req(32'($urandom));
        wait_idle();

        cfg_write(CFG_LIMIT_ADDR, '0);
        alloc_req(32'h1000_0000);
        alloc_req(32'd8);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Summary: %0d requests, %0d register writes, table at %0d of %0d entries, base %h",
                 requests_queued, cfg_writes, blk_count, TB_MAX_BLOCKS, cur_base);
        $display("Outcomes: done %0d, zero size %0d, exhausted %0d, full %0d, unknown %0d, null %0d",
                 status_tally[0], status_tally[1], status_tally[2],
                 status_tally[3], status_tally[4], status_tally[5]);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
